/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by mi_controller
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on aclk, off during reset
`define MI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked on aclk, off during reset
`define MI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/mi_pkg.sv */
// ----------------------------------------------------------------------------
// mi_pkg
// Shared types and constants of the modular inverse core: field width,
// default datapath width, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package mi_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINAL  = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic update;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic nr_zero;
        logic m_lt2;
        logic div_last;
    } status_t;

endpackage

/* design/mi_datapath.sv */
// ----------------------------------------------------------------------------
// mi_datapath
// Euclid registers, bit-serial restoring divider with shift-add coefficient
// accumulation, final sign correction and the result register.
// ----------------------------------------------------------------------------
module mi_datapath #(
    parameter int WORD_BITS = mi_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic [mi_pkg::FIELD_BITS-1:0] value,
    input  logic [mi_pkg::FIELD_BITS-1:0] modulus,
    input  mi_pkg::cmd_t                  cmd,
    output mi_pkg::status_t               sts,
    output logic [mi_pkg::FIELD_BITS-1:0] inverse,
    output logic                          invertible
);

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] m_reg, r_reg, nr_reg, t_reg, nt_reg;
    logic                 t_neg_reg, nt_neg_reg;
    logic [WORD_BITS-1:0] rem_reg, dvd_reg, acc_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [mi_pkg::FIELD_BITS-1:0] inverse_reg;
    logic                 invertible_reg;

    logic [WORD_BITS:0]   rem_shift, rem_sub;
    logic                 q_bit;
    logic [WORD_BITS-1:0] rem_next, acc_next;
    logic [WORD_BITS-1:0] t_red, inv_w;
    logic                 ok;

    // one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[WORD_BITS-1]};
        rem_sub   = rem_shift - {1'b0, nr_reg};
        q_bit     = ~rem_sub[WORD_BITS];
        rem_next  = q_bit ? rem_sub[WORD_BITS-1:0] : rem_shift[WORD_BITS-1:0];
        acc_next  = {acc_reg[WORD_BITS-2:0], 1'b0} + (q_bit ? nt_reg : '0);
    end

    // final reduction, sign fix and invertibility check
    always_comb begin
        t_red = (t_reg >= m_reg) ? (t_reg - m_reg) : t_reg;
        inv_w = (t_neg_reg && (t_red != '0)) ? (m_reg - t_red) : t_red;
        ok    = !sts.m_lt2 && (r_reg == WORD_BITS'(1));
    end

    assign sts.nr_zero  = (nr_reg == '0);
    assign sts.m_lt2    = (m_reg[WORD_BITS-1:1] == '0);
    assign sts.div_last = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg      <= WORD_BITS'(modulus);
            r_reg      <= WORD_BITS'(modulus);
            nr_reg     <= WORD_BITS'(value);
            t_reg      <= '0;
            nt_reg     <= WORD_BITS'(1);
            t_neg_reg  <= 1'b0;
            nt_neg_reg <= 1'b0;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            dvd_reg <= r_reg;
            acc_reg <= '0;
            cnt_reg <= CNT_BITS'(WORD_BITS - 1);
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WORD_BITS-2:0], 1'b0};
            acc_reg <= acc_next;
            cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
        if (cmd.update) begin
            t_reg      <= nt_reg;
            t_neg_reg  <= nt_neg_reg;
            nt_reg     <= t_reg + acc_reg;
            nt_neg_reg <= ~nt_neg_reg;
            r_reg      <= nr_reg;
            nr_reg     <= rem_reg;
        end
        if (cmd.finish) begin
            inverse_reg    <= ok ? mi_pkg::FIELD_BITS'(inv_w) : '0;
            invertible_reg <= ok;
        end
    end

    assign inverse    = inverse_reg;
    assign invertible = invertible_reg;

endmodule

/* design/mi_controller.sv */
// ----------------------------------------------------------------------------
// mi_controller
// Sequencer for the Euclid loop: accepts a beat, steps the divider, applies
// each iteration and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mi_controller (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  mi_pkg::status_t sts,
    output mi_pkg::cmd_t    cmd
);

    mi_pkg::state_t state_reg, state_next;
    logic           out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == mi_pkg::ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            mi_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = mi_pkg::ST_CHECK;
                end
            end
            mi_pkg::ST_CHECK: begin
                if (sts.m_lt2 || sts.nr_zero) begin
                    state_next = mi_pkg::ST_FINAL;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = mi_pkg::ST_DIV;
                end
            end
            mi_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = mi_pkg::ST_UPDATE;
                end
            end
            mi_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = mi_pkg::ST_CHECK;
            end
            mi_pkg::ST_FINAL: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MI_ASSERT_NEXT(a_accept_starts_check, s_valid && s_ready, state_reg == mi_pkg::ST_CHECK)
    `MI_ASSERT_IMPL(a_finish_has_room, cmd.finish, !out_valid_reg || m_ready)
    `MI_ASSERT_NEXT(a_div_ends_in_update, cmd.div_step && sts.div_last, cmd.update)

endmodule

/* design/modular_inverse_core.sv */
// ----------------------------------------------------------------------------
// modular_inverse_core
// Modular inverse by the extended Euclidean algorithm.
//
// Input channel s_*: one beat carries s_value and s_modulus. Result channel
// m_*: one beat per input, m_inverse in 0 .. modulus-1 and m_invertible set
// when the gcd is one; a modulus below two, a zero value or a common factor
// give inverse 0 with the flag clear.
// Each Euclid iteration runs a bit-serial restoring divider, one quotient bit
// per cycle, that also accumulates quotient times coefficient; an iteration
// passes through ST_CHECK, ST_DIV and ST_UPDATE. The number of iterations k
// is at most about 1.44 * WORD_BITS, typically about 0.6 * WORD_BITS for
// random operands.
// One item is in work at a time; s_ready is high only while the sequencer is
// idle. A finished result waits in the output register, so the next beat may
// be accepted while the receiver stalls; that item's result is held back until
// the previous one has been taken.
// Reset (aresetn, synchronous, active low) drops any item in work and clears
// m_valid.
// ----------------------------------------------------------------------------
module modular_inverse_core #(
    parameter int WORD_BITS = mi_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mi_pkg::FIELD_BITS-1:0] s_value,
    input  logic [mi_pkg::FIELD_BITS-1:0] s_modulus,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mi_pkg::FIELD_BITS-1:0] m_inverse,
    output logic                          m_invertible
);

    mi_pkg::cmd_t    cmd;
    mi_pkg::status_t sts;

    mi_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mi_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk       (aclk),
        .value      (s_value),
        .modulus    (s_modulus),
        .cmd        (cmd),
        .sts        (sts),
        .inverse    (m_inverse),
        .invertible (m_invertible)
    );

endmodule
